// ===== rtl/rphit_pkg.sv =====
// Shared types and constants for the ray / polygon edge hit test.
// Used by rphit_ray_front, rphit_edge_eval and ray_polygon_edge_hit_test.
`timescale 1ns / 1ps

package rphit_pkg;

    // Default geometry of the coordinate and direction formats
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int DIR_FRAC_BITS_DEF = 14;

    // Fixed field widths
    localparam int DIR_WIDTH    = 16;
    localparam int LEN_WIDTH    = 32;
    localparam int M_TDATA_W    = 8;

    // Item kinds carried on tuser
    localparam logic FUNC_BEGIN  = 1'b0;
    localparam logic FUNC_VERTEX = 1'b1;

    // Per-item control that travels down the pipeline beside the edge terms
    typedef struct packed {
        logic begin_q;   // item loads a new ray and clears the sticky flag
        logic test1;     // edge from previous vertex to this vertex is tested
        logic test2;     // closing edge from this vertex to the first is tested
        logic eoq;       // item ends the query, one result follows
    } item_ctl_t;

endpackage : rphit_pkg

// ===== rtl/ray_polygon_edge_hit_test.sv =====
// Streamed ray versus polygon edge hit test. A begin transaction (s_tuser = 0)
// loads the ray from origin to origin - ray_length * dir and clears the sticky
// hit flag; each vertex transaction (s_tuser = 1) tests the edge from the
// previous vertex, and with last_vertex set also the closing edge to the first
// vertex. A transaction with s_tlast set yields one result on m_tdata[0]. The
// block takes one transaction per cycle; a transaction passes through the input
// register, delta stage, product stage and sum stage before its result is
// loaded into the result register. Input is held off only while a result
// waits in the result register and the next result is already at the last
// stage. Depends on rphit_pkg, rphit_ray_front and rphit_edge_eval.
`timescale 1ns / 1ps

module ray_polygon_edge_hit_test
    import rphit_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF,
    localparam int S_TDATA_W = ((2 * COORD_WIDTH + 2 * DIR_WIDTH + LEN_WIDTH + 2) + 7) / 8 * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // point_x, point_y, dir_x, dir_y, ray_length, first_vertex, last_vertex
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic                   s_tuser,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hit
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int CW        = COORD_WIDTH;
    localparam int X_LSB     = 0;
    localparam int Y_LSB     = CW;
    localparam int DX_LSB    = 2 * CW;
    localparam int DY_LSB    = 2 * CW + DIR_WIDTH;
    localparam int LEN_LSB   = 2 * CW + 2 * DIR_WIDTH;
    localparam int FIRST_BIT = LEN_LSB + LEN_WIDTH;
    localparam int LAST_BIT  = FIRST_BIT + 1;

    logic advance;

    // Input register
    logic                        a_valid_reg;
    logic                        a_func_reg, a_first_reg, a_last_reg, a_eoq_reg;
    logic signed [CW-1:0]        a_x_reg, a_y_reg;
    logic signed [DIR_WIDTH-1:0] a_dir_x_reg, a_dir_y_reg;
    logic [LEN_WIDTH-1:0]        a_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_tvalid) begin
            a_func_reg  <= s_tuser;
            a_x_reg     <= s_tdata[X_LSB +: CW];
            a_y_reg     <= s_tdata[Y_LSB +: CW];
            a_dir_x_reg <= s_tdata[DX_LSB +: DIR_WIDTH];
            a_dir_y_reg <= s_tdata[DY_LSB +: DIR_WIDTH];
            a_len_reg   <= s_tdata[LEN_LSB +: LEN_WIDTH];
            a_first_reg <= s_tdata[FIRST_BIT];
            a_last_reg  <= s_tdata[LAST_BIT];
            a_eoq_reg   <= s_tlast;
        end
    end

    // Ray setup and edge deltas
    logic               b_valid;
    item_ctl_t          b_ctl;
    logic signed [CW:0] dr_x, dr_y, a1, b1, ox1, oy1, a2, b2, ox2, oy2;

    rphit_ray_front #(
        .COORD_WIDTH   (COORD_WIDTH),
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (a_valid_reg),
        .in_func   (a_func_reg),
        .in_x      (a_x_reg),
        .in_y      (a_y_reg),
        .in_dir_x  (a_dir_x_reg),
        .in_dir_y  (a_dir_y_reg),
        .in_len    (a_len_reg),
        .in_first  (a_first_reg),
        .in_last   (a_last_reg),
        .in_eoq    (a_eoq_reg),
        .out_valid (b_valid),
        .out_ctl   (b_ctl),
        .out_dr_x  (dr_x),
        .out_dr_y  (dr_y),
        .out_a1    (a1),
        .out_b1    (b1),
        .out_ox1   (ox1),
        .out_oy1   (oy1),
        .out_a2    (a2),
        .out_b2    (b2),
        .out_ox2   (ox2),
        .out_oy2   (oy2)
    );

    // Edge tests: previous-to-current and closing edge
    logic hit1, hit2;

    rphit_edge_eval #(.COORD_WIDTH(COORD_WIDTH)) u_edge_prev (
        .aclk (aclk),
        .en   (advance),
        .dr_x (dr_x),
        .dr_y (dr_y),
        .a_in (a1),
        .b_in (b1),
        .ox   (ox1),
        .oy   (oy1),
        .hit  (hit1)
    );

    rphit_edge_eval #(.COORD_WIDTH(COORD_WIDTH)) u_edge_close (
        .aclk (aclk),
        .en   (advance),
        .dr_x (dr_x),
        .dr_y (dr_y),
        .a_in (a2),
        .b_in (b2),
        .ox   (ox2),
        .oy   (oy2),
        .hit  (hit2)
    );

    // Control pipeline alongside the product and sum stages
    logic      c_valid_reg, d_valid_reg;
    item_ctl_t c_ctl_reg, d_ctl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (advance) begin
            c_valid_reg <= b_valid;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            c_ctl_reg <= b_ctl;
            d_ctl_reg <= c_ctl_reg;
        end
    end

    // Sticky flag and result
    logic hit_seen_reg, hit_seen_next;
    logic edge_hit;
    logic m_valid_reg, m_hit_reg;

    assign edge_hit = (d_ctl_reg.test1 && hit1) || (d_ctl_reg.test2 && hit2);
    assign advance  = !(d_valid_reg && d_ctl_reg.eoq && m_valid_reg && !m_tready);
    assign s_tready = advance;

    always_comb begin
        if (d_ctl_reg.begin_q) begin
            hit_seen_next = 1'b0;
        end else begin
            hit_seen_next = hit_seen_reg || edge_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_seen_reg <= 1'b0;
        end else if (advance && d_valid_reg) begin
            hit_seen_reg <= hit_seen_next;
        end
    end

    // Result register: load on a query end, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && d_valid_reg && d_ctl_reg.eoq) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && d_valid_reg && d_ctl_reg.eoq) begin
            m_hit_reg <= hit_seen_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, m_hit_reg};

    // Input is held off only behind a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready && d_valid_reg && d_ctl_reg.eoq))
        else $error("input stalled without a blocked result");

    // A query that ends on its begin reports no hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && d_valid_reg && d_ctl_reg.begin_q && d_ctl_reg.eoq)
        |=> (m_valid_reg && !m_hit_reg))
        else $error("begin with end of query reported a hit");

    // A begin clears the sticky flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && d_valid_reg && d_ctl_reg.begin_q) |=> !hit_seen_reg)
        else $error("sticky hit not cleared by begin");

    // The sticky flag rises only on a tested edge that hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(hit_seen_reg) |-> $past(advance && d_valid_reg && edge_hit))
        else $error("sticky hit set without an edge hit");

    // A taken result with nothing new behind it leaves the output empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tready && !(d_valid_reg && d_ctl_reg.eoq)) |=> !m_valid_reg)
        else $error("result repeated after being taken");

endmodule : ray_polygon_edge_hit_test

// ===== rtl/rphit_ray_front.sv =====
// Ray setup and edge-delta stage: keeps ray and vertex state, forms the
// coordinate differences for both edges of a vertex. Depends on rphit_pkg.
`timescale 1ns / 1ps

module rphit_ray_front
    import rphit_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          in_func,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [DIR_WIDTH-1:0]   in_dir_x,
    input  logic signed [DIR_WIDTH-1:0]   in_dir_y,
    input  logic [LEN_WIDTH-1:0]          in_len,
    input  logic                          in_first,
    input  logic                          in_last,
    input  logic                          in_eoq,
    output logic                          out_valid,
    output item_ctl_t                     out_ctl,
    output logic signed [COORD_WIDTH:0]   out_dr_x,
    output logic signed [COORD_WIDTH:0]   out_dr_y,
    output logic signed [COORD_WIDTH:0]   out_a1,
    output logic signed [COORD_WIDTH:0]   out_b1,
    output logic signed [COORD_WIDTH:0]   out_ox1,
    output logic signed [COORD_WIDTH:0]   out_oy1,
    output logic signed [COORD_WIDTH:0]   out_a2,
    output logic signed [COORD_WIDTH:0]   out_b2,
    output logic signed [COORD_WIDTH:0]   out_ox2,
    output logic signed [COORD_WIDTH:0]   out_oy2
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = LEN_WIDTH + DIR_WIDTH + 1;
    localparam int QW = PW - DIR_FRAC_BITS;
    localparam int EW = ((CW > QW) ? CW : QW) + 1;
    localparam logic signed [EW-1:0] SAT_HI = EW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

    // Ray and vertex state
    logic signed [CW-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic signed [CW-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;

    // Ray end: origin - floor(len * dir / 2^F), saturated
    logic signed [LEN_WIDTH:0] len_s;
    logic signed [PW-1:0]      prod_x, prod_y;
    logic signed [QW-1:0]      q_x, q_y;
    logic signed [EW-1:0]      e_x, e_y;
    logic signed [CW-1:0]      end_x_next, end_y_next;

    assign len_s  = {1'b0, in_len};
    assign prod_x = PW'(len_s) * PW'(in_dir_x);
    assign prod_y = PW'(len_s) * PW'(in_dir_y);
    assign q_x    = prod_x[PW-1:DIR_FRAC_BITS];
    assign q_y    = prod_y[PW-1:DIR_FRAC_BITS];
    assign e_x    = EW'(in_x) - EW'(q_x);
    assign e_y    = EW'(in_y) - EW'(q_y);

    // Clamp the ray end to the coordinate range
    always_comb begin
        if (e_x > SAT_HI) begin
            end_x_next = SAT_HI[CW-1:0];
        end else if (e_x < SAT_LO) begin
            end_x_next = SAT_LO[CW-1:0];
        end else begin
            end_x_next = e_x[CW-1:0];
        end
        if (e_y > SAT_HI) begin
            end_y_next = SAT_HI[CW-1:0];
        end else if (e_y < SAT_LO) begin
            end_y_next = SAT_LO[CW-1:0];
        end else begin
            end_y_next = e_y[CW-1:0];
        end
    end

    // Edge differences; a first vertex closes its own edge against itself
    logic                 is_begin;
    logic signed [CW-1:0] first_x_sel, first_y_sel;

    assign is_begin    = (in_func == FUNC_BEGIN);
    assign first_x_sel = in_first ? in_x : first_x_reg;
    assign first_y_sel = in_first ? in_y : first_y_reg;

    // Update ray and vertex state per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end else if (en && in_valid && is_begin) begin
            start_x_reg <= in_x;
            start_y_reg <= in_y;
            end_x_reg   <= end_x_next;
            end_y_reg   <= end_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid && !is_begin) begin
            if (in_first) begin
                first_x_reg <= in_x;
                first_y_reg <= in_y;
            end
            prev_x_reg <= in_x;
            prev_y_reg <= in_y;
        end
    end

    // Stage register toward the multipliers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctl.begin_q <= is_begin;
            out_ctl.test1   <= !is_begin && !in_first;
            out_ctl.test2   <= !is_begin && in_last;
            out_ctl.eoq     <= in_eoq;
            out_dr_x        <= DW'(end_x_reg) - DW'(start_x_reg);
            out_dr_y        <= DW'(end_y_reg) - DW'(start_y_reg);
            out_a1          <= DW'(prev_y_reg) - DW'(in_y);
            out_b1          <= DW'(in_x) - DW'(prev_x_reg);
            out_ox1         <= DW'(prev_x_reg) - DW'(start_x_reg);
            out_oy1         <= DW'(prev_y_reg) - DW'(start_y_reg);
            out_a2          <= DW'(in_y) - DW'(first_y_sel);
            out_b2          <= DW'(first_x_sel) - DW'(in_x);
            out_ox2         <= DW'(in_x) - DW'(start_x_reg);
            out_oy2         <= DW'(in_y) - DW'(start_y_reg);
        end
    end

endmodule : rphit_ray_front

// ===== rtl/rphit_edge_eval.sv =====
// One edge-against-ray test: registered products, registered sums, then the
// range check on both numerators. Depends on rphit_pkg.
`timescale 1ns / 1ps

module rphit_edge_eval
    import rphit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [COORD_WIDTH:0] dr_x,
    input  logic signed [COORD_WIDTH:0] dr_y,
    input  logic signed [COORD_WIDTH:0] a_in,
    input  logic signed [COORD_WIDTH:0] b_in,
    input  logic signed [COORD_WIDTH:0] ox,
    input  logic signed [COORD_WIDTH:0] oy,
    output logic                        hit
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // Product stage
    logic signed [PW-1:0] p_h0_reg, p_h1_reg, p_n1a_reg, p_n1b_reg, p_n2a_reg, p_n2b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_h0_reg  <= PW'(dr_x) * PW'(a_in);
            p_h1_reg  <= PW'(b_in) * PW'(dr_y);
            p_n1a_reg <= PW'(dr_x) * PW'(oy);
            p_n1b_reg <= PW'(dr_y) * PW'(ox);
            p_n2a_reg <= PW'(a_in) * PW'(ox);
            p_n2b_reg <= PW'(b_in) * PW'(oy);
        end
    end

    // Sum stage: denominator and both numerators
    logic signed [SW-1:0] h_reg, n1_reg, n2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg  <= SW'(p_h0_reg) + SW'(p_h1_reg);
            n1_reg <= SW'(p_n1a_reg) - SW'(p_n1b_reg);
            n2_reg <= SW'(p_n2a_reg) + SW'(p_n2b_reg);
        end
    end

    // Numerator within [0, h) for h > 0, within (h, 0] for h < 0
    function automatic logic in_range(input logic signed [SW-1:0] n,
                                      input logic signed [SW-1:0] h);
        logic h_zero, h_neg, n_neg, n_zero;
        h_zero = (h == '0);
        h_neg  = h[SW-1];
        n_neg  = n[SW-1];
        n_zero = (n == '0);
        if (h_zero) begin
            return 1'b0;
        end else if (!h_neg) begin
            return !n_neg && (n < h);
        end else begin
            return (h < n) && (n_neg || n_zero);
        end
    endfunction

    assign hit = in_range(n1_reg, h_reg) && in_range(n2_reg, h_reg);

endmodule : rphit_edge_eval
